>>> design/ftr_pkg.sv
// Shared types and defaults for the function call trace ring.
// Holds request codes, sequencer states and the result beat layout; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ftr_pkg;

    // default sizes
    localparam int FTR_SYMBOLS    = 64;
    localparam int FTR_RING_DEPTH = 16;
    localparam int FTR_FILES      = 16;

    // fixed field widths of the stream beats
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 144;
    localparam int REQ_W       = 3;
    localparam int CNT_CFG_W   = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 3'd0,
        REQ_CALL   = 3'd1,
        REQ_RET    = 3'd2,
        REQ_EITHER = 3'd3,
        REQ_READ   = 3'd4,
        REQ_CLEAR  = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic        hit;
        logic        direction;
        logic [5:0]  symbol_index;
        logic [3:0]  file_id;
        logic [31:0] rec_source_pc;
        logic [31:0] rec_func_start;
        logic [63:0] rec_timestamp;
    } res_t;

endpackage

`default_nettype wire

>>> design/ftr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the symbol table and the trace ring; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ftr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/function_call_trace_ring_unit.sv
// Top level of the function call trace ring: request sequencer, symbol table scan,
// trace ring and output register. Depends on ftr_pkg and ftr_ram.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------------
//  s_*       | in  | s_tvalid / s_tready    | s_tuser = req_type, s_tdata = request fields
//  m_*       | out | m_tvalid / m_tready    | m_tuser = hit, direction; m_tdata = record
//  cfg_*     | in  | cfg_we (no wait)       | cfg_wdata = symbol_count
//
// Sequencing: one request at a time. Load, clear and unused codes go from IDLE
//   straight to PUSH, a ring read passes through RDWAIT for the registered ring RAM
//   read, and an event scans symbol slots up to the first match (all
//   min(symbol_count, SYMBOLS) when none matches). The scan reads the symbol RAM one slot
//   per cycle, pipelined so slot i is compared while slot i + 1 is read.
// Reset: rst_n clears the sequencer, the write pointer, the ring occupied bits, the
//   symbol count and the output valid. RAM contents are not reset.
// Stalls: a finished result waits in the PUSH state while the output register is full;
//   the previous result drains independently on m_tready.
`timescale 1ns / 1ps
`default_nettype none

module function_call_trace_ring_unit
    import ftr_pkg::*;
#(
    parameter int SYMBOLS    = FTR_SYMBOLS,
    parameter int RING_DEPTH = FTR_RING_DEPTH,
    parameter int FILES      = FTR_FILES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [5:0] entry_index, [37:6] func_addr, [69:38] func_size, [73:70] func_file,
    // [105:74] target_pc, [137:106] source_pc, [201:138] timestamp,
    // [205:202] read_offset, [207:206] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [2:0] req_type
    input  wire logic [REQ_W-1:0]       s_tuser,
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [5:0] symbol_index, [9:6] file_id, [41:10] rec_source_pc,
    // [73:42] rec_func_start, [137:74] rec_timestamp, [143:138] zero
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // [0] hit, [1] direction
    output logic      [1:0]             m_tuser,
    // symbol_count register
    input  wire logic                   cfg_we,
    input  wire logic [CNT_CFG_W-1:0]   cfg_wdata
);

    localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CNT_W  = SYM_W + 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILE_W = (FILES <= 1) ? 1 : ((FILES >= 16) ? 4 : $clog2(FILES));
    localparam int SYM_DW = 64 + FILE_W;
    localparam int REC_W  = 65 + SYM_W + FILE_W + 64;
    localparam int MW     = PTR_W + 4;
    localparam logic [MW-1:0] DEP_M = MW'(RING_DEPTH);

    // unpack the request beat
    logic [5:0]  in_entry;
    logic [31:0] in_addr;
    logic [31:0] in_size;
    logic [3:0]  in_file;
    logic [31:0] in_target;
    logic [31:0] in_source;
    logic [63:0] in_stamp;
    logic [3:0]  in_offset;

    assign in_entry  = s_tdata[5:0];
    assign in_addr   = s_tdata[37:6];
    assign in_size   = s_tdata[69:38];
    assign in_file   = s_tdata[73:70];
    assign in_target = s_tdata[105:74];
    assign in_source = s_tdata[137:106];
    assign in_stamp  = s_tdata[201:138];
    assign in_offset = s_tdata[205:202];

    // state
    state_t                 state_reg, state_next;
    logic [CNT_CFG_W-1:0]   symbol_count_reg;
    logic [CNT_W-1:0]       lim_reg, lim_next;
    logic [SYM_W-1:0]       idx_reg, idx_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic [RING_DEPTH-1:0]  occ_reg, occ_next;
    logic                   m_tvalid_reg;
    res_t                   res_reg, res_next;
    res_t                   out_reg;
    logic                   out_load;

    // request payload held for the scan and the ring read
    req_t                   kind_reg;
    logic [31:0]            tgt_reg;
    logic [31:0]            src_reg;
    logic [63:0]            stamp_reg;
    logic [PTR_W-1:0]       pos_reg;

    // memory ports
    logic                   sym_we;
    logic [SYM_W-1:0]       sym_waddr;
    logic [SYM_DW-1:0]      sym_wdata;
    logic [SYM_W-1:0]       sym_raddr;
    logic [SYM_DW-1:0]      sym_rdata;
    logic                   ring_we;
    logic [REC_W-1:0]       ring_wdata;
    logic [PTR_W-1:0]       ring_raddr;
    logic [REC_W-1:0]       ring_rdata;

    logic                   in_beat;
    logic [CNT_W-1:0]       lim_calc;
    logic [PTR_W-1:0]       pos_calc;
    logic [FILE_W-1:0]      file_clamped;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // slots searched: symbol_count clipped to the table size
    always_comb
    begin
        if (int'(symbol_count_reg) > SYMBOLS)
        begin
            lim_calc = CNT_W'(SYMBOLS);
        end
        else
        begin
            lim_calc = CNT_W'(symbol_count_reg);
        end
    end

    // clamp out-of-range image ids to the last one
    always_comb
    begin
        if (int'(in_file) >= FILES)
        begin
            file_clamped = FILE_W'(FILES - 1);
        end
        else
        begin
            file_clamped = FILE_W'(in_file);
        end
    end

    // ring position of a read: (wp + offset) mod RING_DEPTH, offset reduced by
    // conditional subtraction of 8, 4, 2 and 1 times the depth
    always_comb
    begin
        logic [MW-1:0] off;
        logic [MW-1:0] sum;
        off = MW'(in_offset);
        for (int k = 3; k >= 0; k--)
        begin
            if (off >= (DEP_M << k))
            begin
                off = off - (DEP_M << k);
            end
        end
        sum = MW'(wp_reg) + off;
        if (sum >= DEP_M)
        begin
            sum = sum - DEP_M;
        end
        pos_calc = sum[PTR_W-1:0];
    end

    // symbol table: {file, length, start}
    assign sym_waddr = SYM_W'(in_entry);
    assign sym_wdata = {file_clamped, in_size, in_addr};

    ftr_ram #(
        .WIDTH (SYM_DW),
        .DEPTH (SYMBOLS),
        .ADDR_W(SYM_W)
    ) u_sym_ram (
        .clk  (clk),
        .we   (sym_we),
        .waddr(sym_waddr),
        .wdata(sym_wdata),
        .raddr(sym_raddr),
        .rdata(sym_rdata)
    );

    // trace ring: {stamp, file, sym, dir, start, src}
    ftr_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_DEPTH),
        .ADDR_W(PTR_W)
    ) u_ring_ram (
        .clk  (clk),
        .we   (ring_we),
        .waddr(wp_reg),
        .wdata(ring_wdata),
        .raddr(ring_raddr),
        .rdata(ring_rdata)
    );

    // compare the slot whose data just came out of the symbol RAM
    logic [31:0]       s_start;
    logic [31:0]       s_len;
    logic [FILE_W-1:0] s_file;
    logic              is_call;
    logic              is_ret;
    logic [CNT_W-1:0]  idx_inc;

    assign s_start = sym_rdata[31:0];
    assign s_len   = sym_rdata[63:32];
    assign s_file  = sym_rdata[64 +: FILE_W];
    assign is_call = (kind_reg != REQ_RET) && (tgt_reg == s_start);
    assign is_ret  = (kind_reg != REQ_CALL) && (tgt_reg > s_start) &&
                     ((tgt_reg - s_start) < s_len);
    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);

    assign ring_wdata = {stamp_reg, s_file, idx_reg, !is_call, s_start, src_reg};

    // sequencer: next state and memory controls
    always_comb
    begin
        state_next = state_reg;
        lim_next   = lim_reg;
        idx_next   = idx_reg;
        wp_next    = wp_reg;
        occ_next   = occ_reg;
        res_next   = res_reg;
        out_load   = 1'b0;
        sym_we     = 1'b0;
        sym_raddr  = idx_inc[SYM_W-1:0];
        ring_we    = 1'b0;
        ring_raddr = pos_calc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_next = '0;
                    unique case (req_t'(s_tuser))
                        REQ_LOAD:
                        begin
                            // drop loads beyond the table
                            sym_we     = (int'(in_entry) < SYMBOLS);
                            state_next = ST_PUSH;
                        end
                        REQ_CALL, REQ_RET, REQ_EITHER:
                        begin
                            lim_next  = lim_calc;
                            idx_next  = '0;
                            sym_raddr = '0;
                            if (lim_calc == '0)
                            begin
                                state_next = ST_PUSH;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_READ:
                        begin
                            state_next = ST_RDWAIT;
                        end
                        REQ_CLEAR:
                        begin
                            occ_next   = '0;
                            wp_next    = '0;
                            state_next = ST_PUSH;
                        end
                        default:
                        begin
                            state_next = ST_PUSH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (is_call || is_ret)
                begin
                    // record the first match and advance the write pointer
                    ring_we          = 1'b1;
                    occ_next[wp_reg] = 1'b1;
                    wp_next = (int'(wp_reg) == RING_DEPTH - 1) ? '0 : wp_reg + PTR_W'(1);
                    res_next.hit            = 1'b1;
                    res_next.direction      = !is_call;
                    res_next.symbol_index   = 6'(idx_reg);
                    res_next.file_id        = 4'(s_file);
                    res_next.rec_source_pc  = src_reg;
                    res_next.rec_func_start = s_start;
                    res_next.rec_timestamp  = stamp_reg;
                    state_next = ST_PUSH;
                end
                else if (idx_inc == lim_reg)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    idx_next = idx_inc[SYM_W-1:0];
                end
            end
            ST_RDWAIT:
            begin
                if (occ_reg[pos_reg])
                begin
                    res_next.hit            = 1'b1;
                    res_next.rec_source_pc  = ring_rdata[31:0];
                    res_next.rec_func_start = ring_rdata[63:32];
                    res_next.direction      = ring_rdata[64];
                    res_next.symbol_index   = 6'(ring_rdata[65 +: SYM_W]);
                    res_next.file_id        = 4'(ring_rdata[65 + SYM_W +: FILE_W]);
                    res_next.rec_timestamp  = ring_rdata[65 + SYM_W + FILE_W +: 64];
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            symbol_count_reg <= '0;
            lim_reg          <= '0;
            idx_reg          <= '0;
            wp_reg           <= '0;
            occ_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lim_reg   <= lim_next;
            idx_reg   <= idx_next;
            wp_reg    <= wp_next;
            occ_reg   <= occ_next;
            if (cfg_we)
            begin
                symbol_count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_beat)
        begin
            kind_reg  <= req_t'(s_tuser);
            tgt_reg   <= in_target;
            src_reg   <= in_source;
            stamp_reg <= in_stamp;
            pos_reg   <= pos_calc;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg.rec_timestamp, out_reg.rec_func_start,
                       out_reg.rec_source_pc, out_reg.file_id, out_reg.symbol_index};
    assign m_tuser  = {out_reg.direction, out_reg.hit};

    // checks
    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(wp_reg) < RING_DEPTH)
        else $error("write pointer beyond ring depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (s_tuser == REQ_CLEAR)) |=> ((occ_reg == '0) && (wp_reg == '0)))
        else $error("clear did not empty the ring");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < lim_reg))
        else $error("scan index beyond symbol count");

    a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_PUSH))
        else $error("result beat raised outside the push state");

endmodule

`default_nettype wire

>>> tb/tb_function_call_trace_ring_unit.sv
// Self-checking bench for function_call_trace_ring_unit: symbol loads, jump events,
// ring reads and clears driven over the request stream, results scored against a predictor.
// Depends on ftr_pkg and the function_call_trace_ring_unit RTL only.
`timescale 1ns / 1ps

module tb_function_call_trace_ring_unit;
    import ftr_pkg::*;

    // Request codes the block treats as no-ops; the package enum stops at clear.
    localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

    localparam int PHASE_ITEMS = 205;
    localparam int PHASES      = 8;
    localparam int DRAIN_LIMIT = 20000;

    // One request beat, field by field, at the widths of the s_tdata layout.
    typedef struct {
        logic [REQ_W-1:0] req_type;
        logic [5:0]       entry_index;
        logic [31:0]      func_addr;
        logic [31:0]      func_size;
        logic [3:0]       func_file;
        logic [31:0]      target_pc;
        logic [31:0]      source_pc;
        logic [63:0]      timestamp;
        logic [3:0]       read_offset;
    } trace_req_t;

    // Holds a private copy of the symbol table and trace ring, works out the
    // record each accepted request must produce and scores the returned beats.
    class trace_ring_scoreboard;
        logic [CNT_CFG_W-1:0] symbol_count;
        logic [31:0]          sym_start  [FTR_SYMBOLS];
        logic [31:0]          sym_length [FTR_SYMBOLS];
        logic [3:0]           sym_file   [FTR_SYMBOLS];
        bit                   ring_used  [FTR_RING_DEPTH];
        res_t                 ring_entry [FTR_RING_DEPTH];
        int unsigned          wr_ptr;
        res_t                 pending_records[$];
        int                   errors;

        function new();
            symbol_count = '0;
            wr_ptr       = 0;
            errors       = 0;
            foreach (ring_used[i])
                ring_used[i] = 1'b0;
        endfunction

        function int scan_len();
            return (symbol_count > FTR_SYMBOLS) ? FTR_SYMBOLS : int'(symbol_count);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void accept_request(trace_req_t r);
            res_t        rec;
            bit          is_call;
            bit          is_ret;
            int unsigned pos;
            rec = '0;
            case (r.req_type)
                REQ_LOAD:
                begin
                    sym_start[r.entry_index]  = r.func_addr;
                    sym_length[r.entry_index] = r.func_size;
                    sym_file[r.entry_index]   = r.func_file;
                end
                REQ_CALL, REQ_RET, REQ_EITHER:
                begin
                    // first slot in index order wins; call is tried before return
                    for (int i = 0; i < scan_len() && !rec.hit; i++)
                    begin
                        is_call = (r.req_type != REQ_RET) && (r.target_pc == sym_start[i]);
                        is_ret  = (r.req_type != REQ_CALL) && (r.target_pc > sym_start[i])
                                  && ((r.target_pc - sym_start[i]) < sym_length[i]);
                        if (is_call || is_ret)
                        begin
                            rec.hit            = 1'b1;
                            rec.direction      = !is_call;
                            rec.symbol_index   = 6'(i);
                            rec.file_id        = sym_file[i];
                            rec.rec_source_pc  = r.source_pc;
                            rec.rec_func_start = sym_start[i];
                            rec.rec_timestamp  = r.timestamp;
                            ring_entry[wr_ptr] = rec;
                            ring_used[wr_ptr]  = 1'b1;
                            wr_ptr = (wr_ptr + 1) % FTR_RING_DEPTH;
                        end
                    end
                end
                REQ_READ:
                begin
                    pos = (wr_ptr + r.read_offset) % FTR_RING_DEPTH;
                    if (ring_used[pos])
                        rec = ring_entry[pos];
                end
                REQ_CLEAR:
                begin
                    foreach (ring_used[i])
                        ring_used[i] = 1'b0;
                    wr_ptr = 0;
                end
                default: ;
            endcase
            pending_records.push_back(rec);
        endfunction

        task check_record(res_t got);
            res_t want;
            if (pending_records.size() == 0)
            begin
                report($sformatf("result beat with nothing pending: %h", got));
                return;
            end
            want = pending_records.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit %h, want %h", got.hit, want.hit));
            if (got.direction !== want.direction)
                report($sformatf("direction %h, want %h", got.direction, want.direction));
            if (got.symbol_index !== want.symbol_index)
                report($sformatf("symbol_index %h, want %h",
                                 got.symbol_index, want.symbol_index));
            if (got.file_id !== want.file_id)
                report($sformatf("file_id %h, want %h", got.file_id, want.file_id));
            if (got.rec_source_pc !== want.rec_source_pc)
                report($sformatf("rec_source_pc %h, want %h",
                                 got.rec_source_pc, want.rec_source_pc));
            if (got.rec_func_start !== want.rec_func_start)
                report($sformatf("rec_func_start %h, want %h",
                                 got.rec_func_start, want.rec_func_start));
            if (got.rec_timestamp !== want.rec_timestamp)
                report($sformatf("rec_timestamp %h, want %h",
                                 got.rec_timestamp, want.rec_timestamp));
        endtask
    endclass

    // Block inputs start at known values; everything after reset moves on clock edges.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CNT_CFG_W-1:0]   cfg_wdata = '0;

    // Set for the last phase: both sides then run without gaps or stalls.
    bit quiet_tail = 1'b0;

    trace_ring_scoreboard sb;

    function_call_trace_ring_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop: several times the slowest legal run (every event scanning all
    // slots, every beat waiting out the longest gap and stall).
    initial
    begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Fill every field with noise; the caller overwrites the ones that matter.
    function automatic trace_req_t noise_req(logic [REQ_W-1:0] kind);
        trace_req_t r;
        r.req_type    = kind;
        r.entry_index = 6'($urandom);
        r.func_addr   = $urandom;
        r.func_size   = $urandom;
        r.func_file   = 4'($urandom);
        r.target_pc   = $urandom;
        r.source_pc   = $urandom;
        r.timestamp   = {$urandom, $urandom};
        r.read_offset = 4'($urandom);
        return r;
    endfunction

    function automatic trace_req_t load_req(int idx, logic [31:0] addr, logic [31:0] size,
                                            logic [3:0] file);
        trace_req_t r;
        r             = noise_req(REQ_LOAD);
        r.entry_index = 6'(idx);
        r.func_addr   = addr;
        r.func_size   = size;
        r.func_file   = file;
        return r;
    endfunction

    function automatic trace_req_t event_req(logic [REQ_W-1:0] kind, logic [31:0] target,
                                             logic [31:0] src, logic [63:0] stamp);
        trace_req_t r;
        r           = noise_req(kind);
        r.target_pc = target;
        r.source_pc = src;
        r.timestamp = stamp;
        return r;
    endfunction

    function automatic trace_req_t read_req(logic [3:0] offset);
        trace_req_t r;
        r             = noise_req(REQ_READ);
        r.read_offset = offset;
        return r;
    endfunction

    // Load a slot with a plausible function: mostly small bodies, sometimes empty,
    // one byte, huge, or starting at an address one of the first dup_limit slots already uses.
    function automatic trace_req_t random_load(int idx, int dup_limit);
        logic [31:0] addr;
        logic [31:0] size;
        addr = $urandom;
        if (dup_limit > 0 && $urandom_range(0, 7) == 0)
            addr = sb.sym_start[$urandom_range(0, dup_limit - 1)];
        case ($urandom_range(0, 9))
            0:       size = 32'h0;
            1:       size = 32'h1;
            2:       size = 32'hFFFF_FFFF;
            3:       size = $urandom;
            default: size = $urandom_range(2, 4096);
        endcase
        return load_req(idx, addr, size, 4'($urandom));
    endfunction

    // Random traffic. Most events aim at a slot that is searched, so the scan
    // runs to varied depths and hits; the rest land on edges or anywhere.
    function automatic trace_req_t random_req();
        trace_req_t       r;
        int               sel;
        int               mode;
        int               slot;
        logic [REQ_W-1:0] kind;
        logic [31:0]      st;
        logic [31:0]      len;
        logic [31:0]      body;
        logic [31:0]      target;
        sel = $urandom_range(0, 99);
        if (sel < 14)
            r = random_load($urandom_range(0, FTR_SYMBOLS - 1), FTR_SYMBOLS);
        else if (sel < 70)
        begin
            kind = (sel < 34) ? REQ_CALL : (sel < 54) ? REQ_RET : REQ_EITHER;
            mode = $urandom_range(0, 9);
            target = $urandom;
            if (sb.scan_len() > 0 && mode < 8)
            begin
                slot = $urandom_range(0, sb.scan_len() - 1);
                st   = sb.sym_start[slot];
                len  = sb.sym_length[slot];
                body = (len > 1) ? st + 1 + ($urandom % (len - 1)) : st + 1;
                case (mode)
                    5:       target = st + len;   // one past the end
                    6:       target = st - 1;
                    7:       target = st;
                    default: target = (kind == REQ_CALL || (kind == REQ_EITHER && mode[0]))
                                      ? st : body;
                endcase
            end
            r = event_req(kind, target, $urandom, {$urandom, $urandom});
        end
        else if (sel < 92)
            r = read_req(4'($urandom));
        else if (sel < 95)
            r = noise_req(REQ_CLEAR);
        else
            r = noise_req(sel[0] ? REQ_UNUSED_A : REQ_UNUSED_B);
        return r;
    endfunction

    // Present one request beat, with an optional gap in front, and hold it until
    // the block takes it. Hand the accepted beat to the predictor.
    task automatic send_beat(input trace_req_t r);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= {2'b00, r.read_offset, r.timestamp, r.source_pc, r.target_pc,
                     r.func_file, r.func_size, r.func_addr, r.entry_index};
        do
            @(posedge clk);
        while (!s_tready);
        sb.accept_request(r);
    endtask

    // Drop valid and wait until every predicted record has come back.
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_records.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        @(posedge clk);
    endtask

    // Write symbol_count; only called with the block idle.
    task automatic write_count(input logic [CNT_CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.symbol_count = value;
    endtask

    // Result side: accept in random bursts of ready, with ready dropped at random times to stall.
    initial
    begin : result_sink
        int hold;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Score every result beat that the block hands over.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit            = m_tuser[0];
            got.direction      = m_tuser[1];
            got.symbol_index   = m_tdata[5:0];
            got.file_id        = m_tdata[9:6];
            got.rec_source_pc  = m_tdata[41:10];
            got.rec_func_start = m_tdata[73:42];
            got.rec_timestamp  = m_tdata[137:74];
            sb.check_record(got);
        end
    end

    initial
    begin : stimulus
        logic [CNT_CFG_W-1:0] count_plan [PHASES];
        sb = new();
        // Counts per phase: full table, one slot, the largest register value,
        // nothing searched, above the table size, a random depth, partial, full.
        count_plan = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd100, 7'd0, 7'd40, 7'd64};
        count_plan[5] = 7'($urandom_range(2, 63));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // Count is zero out of reset: an event searches nothing and misses.
        send_beat(event_req(REQ_CALL, 32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        // Empty ring: a read returns an all-zero record.
        send_beat(read_req(4'd0));
        send_beat(noise_req(REQ_UNUSED_A));
        send_beat(noise_req(REQ_UNUSED_B));
        // Small table with crafted corners:
        //   slot 1 ends past the top of the address space (sum must not wrap),
        //   slot 2 shares slot 0's start (lower index wins),
        //   slot 3 is empty at address zero,
        //   slot 5 sits inside slot 4 (return in slot 4 beats call in slot 5).
        send_beat(load_req(0, 32'h0000_1000, 32'h0000_0100, 4'd3));
        send_beat(load_req(1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd15));
        send_beat(load_req(2, 32'h0000_1000, 32'h0000_0010, 4'd1));
        send_beat(load_req(3, 32'h0000_0000, 32'h0000_0000, 4'd0));
        send_beat(load_req(4, 32'h0000_2000, 32'h0000_2000, 4'd7));
        send_beat(load_req(5, 32'h0000_2800, 32'h0000_0100, 4'd9));
        send_beat(load_req(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
        wait_drained();
        write_count(7'd6);

        send_beat(event_req(REQ_CALL, 32'h0000_1000, 32'h0000_0000, 64'h0));
        send_beat(event_req(REQ_RET, 32'h0000_10FF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        // one past the end of slot 0: no slot holds it
        send_beat(event_req(REQ_RET, 32'h0000_1100, 32'h1234_5678, 64'h1));
        send_beat(event_req(REQ_RET, 32'hFFFF_FFFF, 32'h8000_0000, 64'h8000_0000_0000_0000));
        send_beat(event_req(REQ_CALL, 32'h0000_0000, 32'h0000_0004, 64'h2));
        send_beat(event_req(REQ_EITHER, 32'h0000_2800, 32'h0000_0008, 64'h3));
        send_beat(event_req(REQ_EITHER, 32'h0000_2000, 32'h0000_000C, 64'h4));
        // a return to the first byte is not strictly inside
        send_beat(event_req(REQ_RET, 32'h0000_1000, 32'h0000_0010, 64'h5));
        send_beat(read_req(4'd10));
        send_beat(read_req(4'd15));
        send_beat(read_req(4'd0));
        send_beat(noise_req(REQ_CLEAR));
        send_beat(read_req(4'd10));
        send_beat(event_req(REQ_CALL, 32'h0000_1000, 32'h0000_0014, 64'h6));
        send_beat(read_req(4'd0));

        // ---- fill the whole table so any count is safe to search ----
        for (int i = 0; i < FTR_SYMBOLS; i++)
            send_beat(random_load(i, i));

        // ---- random phases, one count setting each ----
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_count(count_plan[p]);
            quiet_tail = (p == PHASES - 1);
            repeat (PHASE_ITEMS) send_beat(random_req());
        end

        // Let the last records come back, then give the pipeline time to settle.
        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.pending_records.size() != 0)
            sb.report($sformatf("%0d records never arrived", sb.pending_records.size()));

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
